FILE: hdl/wsts_pkg.sv
`default_nettype none

package wsts_pkg;

  // default build sizes
  localparam int WorkersDef    = 8;
  localparam int DequeDepthDef = 1024;
  localparam int InboxDepthDef = 256;
  localparam int DrainBatchDef = 32;

  // fixed field widths
  localparam int TokW  = 32;
  localparam int PendW = 16;

  // input word modes
  localparam logic [1:0] ModeExtSubmit = 2'd0;
  localparam logic [1:0] ModeLocSubmit = 2'd1;
  localparam logic [1:0] ModeRequest   = 2'd2;
  localparam logic [1:0] ModeComplete  = 2'd3;

  // result kinds
  localparam logic [2:0] KindNone     = 3'd0;
  localparam logic [2:0] KindGranted  = 3'd1;
  localparam logic [2:0] KindInline   = 3'd2;
  localparam logic [2:0] KindAccepted = 3'd3;
  localparam logic [2:0] KindRejected = 3'd4;

  typedef enum logic [3:0] {
    StIdle,
    StRrMod,
    StExtProbe,
    StLocal,
    StComplete,
    StRequest,
    StDrain,
    StDrainWr,
    StStealInit,
    StStealMod,
    StSteal,
    StGrant
  } state_e;

endpackage

`default_nettype wire

FILE: hdl/work_stealing_task_scheduler.sv
`default_nettype none

// Work-stealing task distributor. Every worker owns a bounded deque and a FIFO
// inbox, both held in single-port synchronous memories with registered reads;
// the per-worker indices sit in flip-flops. One input word is taken at a time
// and in_ready_o stays low until all its results have been handed to the
// output register. An external submit first walks the modulo of the
// round-robin start, then probes the inboxes in turn until it finds one
// that is not full. A request takes the newest word of its own deque if
// there is one; otherwise it drains up to DRAIN_BATCH inbox words (memory
// read, then write-back into the deque, or an inline result while the deque
// is full) and then takes its newest deque word; if nothing was moved, a
// steal walks one victim per cycle before the read and grant. A receiver
// that holds the output register stalls any step that emits a result. No
// clearing pass is needed after reset.

module work_stealing_task_scheduler
  import wsts_pkg::*;
#(
  parameter int WORKERS     = WorkersDef,
  parameter int DEQUE_DEPTH = DequeDepthDef,
  parameter int INBOX_DEPTH = InboxDepthDef,
  parameter int DRAIN_BATCH = DrainBatchDef
) (
  input  wire logic             clk_i,
  input  wire logic             rst_ni,
  input  wire logic             cfg_we_i,
  input  wire logic [3:0]       cfg_data_i,
  input  wire logic             in_valid_i,
  output logic                  in_ready_o,
  input  wire logic [1:0]       mode_i,
  input  wire logic [2:0]       worker_id_i,
  input  wire logic [TokW-1:0]  task_token_i,
  output logic                  out_valid_o,
  input  wire logic             out_ready_i,
  output logic [2:0]            kind_o,
  output logic [TokW-1:0]       task_out_o,
  output logic [2:0]            target_worker_o,
  output logic                  last_o,
  output logic                  all_idle_o
);

  localparam int WW    = (WORKERS > 1) ? $clog2(WORKERS) : 1;
  localparam int NW    = $clog2(WORKERS + 1);
  localparam int DQI_W = $clog2(2 * DEQUE_DEPTH);
  localparam int IB_W  = $clog2(INBOX_DEPTH);
  localparam int IBC_W = $clog2(INBOX_DEPTH + 1);
  localparam int DQA_W = $clog2(WORKERS * DEQUE_DEPTH);
  localparam int IBA_W = $clog2(WORKERS * INBOX_DEPTH);
  localparam int KB_W  = $clog2(DRAIN_BATCH + 1);
  localparam int CW    = (KB_W > NW + 1) ? KB_W : NW + 1;

  // per-worker indices
  logic [DQI_W-1:0] top_q   [WORKERS];
  logic [DQI_W-1:0] bot_q   [WORKERS];
  logic [IB_W-1:0]  head_q  [WORKERS];
  logic [IBC_W-1:0] icnt_q  [WORKERS];
  logic [WW-1:0]    cur_q   [WORKERS];

  // task stores
  logic [TokW-1:0] dq_mem [WORKERS * DEQUE_DEPTH];
  logic [TokW-1:0] ib_mem [WORKERS * INBOX_DEPTH];

  state_e            state_q, state_d;
  logic [3:0]        cfg_q;
  logic [2:0]        wid_q;
  logic [TokW-1:0]   tok_q;
  logic [WW-1:0]     w_q, w_d;
  logic [NW-1:0]     x_q, x_d;
  logic [CW-1:0]     k_q, k_d;
  logic              moved_q, moved_d;
  logic [WW-1:0]     src_q, src_d;
  logic              rd_ib_q, rd_ib_d;
  logic [WW-1:0]     rr_q, rr_d;
  logic [PendW-1:0]  pend_q, pend_d;

  logic              out_valid_q, out_valid_d;
  logic [2:0]        kind_q;
  logic [TokW-1:0]   task_q;
  logic [2:0]        tgt_q;
  logic              last_q, all_idle_q;

  logic [TokW-1:0]   dq_rd_q, ib_rd_q;

  // combinational controls
  logic              in_acc, out_free;
  logic [6:0]        n7;
  logic [NW-1:0]     n;
  logic              wid_bad;
  logic [WW-1:0]     wid_w;
  logic [WW-1:0]     w_next;
  logic [DQI_W-1:0]  top_w, bot_w, bot_m1, bot_p1, top_p1;
  logic [DQI_W-1:0]  dq_cnt;
  logic [IB_W-1:0]   head_w, head_p1;
  logic [IBC_W-1:0]  icnt_w;
  logic [IBC_W:0]    tail_sum;
  logic [IB_W-1:0]   tail_slot;
  logic              dq_full, dq_empty, ib_full, ib_empty;

  logic              top_we, bot_we, head_we, icnt_we, cur_we;
  logic [DQI_W-1:0]  top_wd, bot_wd;
  logic [IB_W-1:0]   head_wd;
  logic [IBC_W-1:0]  icnt_wd;

  logic              dq_we, dq_re, ib_we, ib_re;
  logic [DQI_W-1:0]  dq_idx;
  logic [IB_W-1:0]   ib_slot;
  logic [DQA_W-1:0]  dq_addr;
  logic [IBA_W-1:0]  ib_addr;
  logic [TokW-1:0]   dq_wdata;

  logic              emit;
  logic [2:0]        e_kind;
  logic [TokW-1:0]   e_task;
  logic [2:0]        e_tgt;
  logic              e_last;

  function automatic logic [DQI_W-1:0] dq_slot(input logic [DQI_W-1:0] idx);
    logic [DQI_W-1:0] r;
    r = (idx >= DQI_W'(DEQUE_DEPTH)) ? idx - DQI_W'(DEQUE_DEPTH) : idx;
    return r;
  endfunction

  assign in_acc   = in_valid_i && in_ready_o;
  assign out_free = !out_valid_q || out_ready_i;

  // effective worker count
  always_comb begin
    if (cfg_q == 4'd0) begin
      n7 = 7'd1;
    end else if (7'(cfg_q) > 7'(WORKERS)) begin
      n7 = 7'(WORKERS);
    end else begin
      n7 = 7'(cfg_q);
    end
  end
  assign n       = NW'(n7);
  assign wid_bad = 7'(wid_q) >= n7;
  assign wid_w   = WW'(wid_q);
  assign w_next  = (NW'(w_q) + NW'(1) == n) ? '0 : w_q + WW'(1);

  // index arithmetic for the worker under w_q
  assign top_w   = top_q[w_q];
  assign bot_w   = bot_q[w_q];
  assign head_w  = head_q[w_q];
  assign icnt_w  = icnt_q[w_q];
  assign dq_cnt  = (bot_w >= top_w) ? bot_w - top_w
                                    : bot_w + DQI_W'(2 * DEQUE_DEPTH) - top_w;
  assign bot_m1  = (bot_w == '0) ? DQI_W'(2 * DEQUE_DEPTH - 1) : bot_w - DQI_W'(1);
  assign bot_p1  = (bot_w == DQI_W'(2 * DEQUE_DEPTH - 1)) ? '0 : bot_w + DQI_W'(1);
  assign top_p1  = (top_w == DQI_W'(2 * DEQUE_DEPTH - 1)) ? '0 : top_w + DQI_W'(1);
  assign head_p1 = (head_w == IB_W'(INBOX_DEPTH - 1)) ? '0 : head_w + IB_W'(1);
  assign tail_sum  = (IBC_W + 1)'(head_w) + (IBC_W + 1)'(icnt_w);
  assign tail_slot = (tail_sum >= (IBC_W + 1)'(INBOX_DEPTH))
                     ? IB_W'(tail_sum - (IBC_W + 1)'(INBOX_DEPTH)) : IB_W'(tail_sum);
  assign dq_full  = dq_cnt >= DQI_W'(DEQUE_DEPTH);
  assign dq_empty = dq_cnt == '0;
  assign ib_full  = icnt_w >= IBC_W'(INBOX_DEPTH);
  assign ib_empty = icnt_w == '0;

  // memory addresses
  assign dq_addr = DQA_W'(w_q) * DQA_W'(DEQUE_DEPTH) + DQA_W'(dq_slot(dq_idx));
  assign ib_addr = IBA_W'(w_q) * IBA_W'(INBOX_DEPTH) + IBA_W'(ib_slot);

  // next state and datapath control
  always_comb begin
    state_d  = state_q;
    w_d      = w_q;
    x_d      = x_q;
    k_d      = k_q;
    moved_d  = moved_q;
    src_d    = src_q;
    rd_ib_d  = rd_ib_q;
    rr_d     = rr_q;
    pend_d   = pend_q;
    in_ready_o = 1'b0;
    top_we = 1'b0; top_wd = top_p1;
    bot_we = 1'b0; bot_wd = bot_p1;
    head_we = 1'b0; head_wd = head_p1;
    icnt_we = 1'b0; icnt_wd = icnt_w;
    cur_we = 1'b0;
    dq_we = 1'b0; dq_re = 1'b0; dq_idx = bot_w; dq_wdata = tok_q;
    ib_we = 1'b0; ib_re = 1'b0; ib_slot = head_w;
    emit = 1'b0; e_kind = KindNone; e_task = '0; e_tgt = wid_q; e_last = 1'b1;

    unique case (state_q)
      StIdle: begin
        in_ready_o = 1'b1;
        if (in_valid_i) begin
          w_d = WW'(worker_id_i);
          unique case (mode_i)
            ModeExtSubmit: begin
              x_d     = NW'(rr_q);
              state_d = StRrMod;
            end
            ModeLocSubmit: state_d = StLocal;
            ModeRequest:   state_d = StRequest;
            ModeComplete:  state_d = StComplete;
            default:       state_d = StIdle;
          endcase
        end
      end

      // start index modulo the worker count
      StRrMod: begin
        if (x_q >= n) begin
          x_d = x_q - n;
        end else begin
          w_d     = WW'(x_q);
          rr_d    = (x_q + NW'(1) == n) ? '0 : WW'(x_q + NW'(1));
          k_d     = '0;
          state_d = StExtProbe;
        end
      end

      // probe one inbox per cycle
      StExtProbe: begin
        if (!ib_full) begin
          if (out_free) begin
            ib_we   = 1'b1;
            ib_slot = tail_slot;
            icnt_we = 1'b1;
            icnt_wd = icnt_w + IBC_W'(1);
            if (pend_q != '1) pend_d = pend_q + PendW'(1);
            emit    = 1'b1;
            e_kind  = KindAccepted;
            e_tgt   = 3'(w_q);
            state_d = StIdle;
          end
        end else if (k_q == CW'(n - NW'(1))) begin
          if (out_free) begin
            emit    = 1'b1;
            e_kind  = KindRejected;
            e_tgt   = 3'd0;
            state_d = StIdle;
          end
        end else begin
          k_d = k_q + CW'(1);
          w_d = w_next;
        end
      end

      StLocal: begin
        if (out_free) begin
          emit    = 1'b1;
          state_d = StIdle;
          if (wid_bad) begin
            e_kind = KindRejected;
          end else begin
            if (pend_q != '1) pend_d = pend_q + PendW'(1);
            if (!dq_full) begin
              dq_we  = 1'b1;
              bot_we = 1'b1;
              e_kind = KindAccepted;
            end else begin
              e_kind = KindInline;
              e_task = tok_q;
            end
          end
        end
      end

      StComplete: begin
        if (out_free) begin
          if (pend_q != '0) pend_d = pend_q - PendW'(1);
          emit    = 1'b1;
          state_d = StIdle;
        end
      end

      // own deque, newest first
      StRequest: begin
        if (wid_bad) begin
          if (out_free) begin
            emit    = 1'b1;
            state_d = StIdle;
          end
        end else if (!dq_empty) begin
          bot_we  = 1'b1;
          bot_wd  = bot_m1;
          dq_re   = 1'b1;
          dq_idx  = bot_m1;
          rd_ib_d = 1'b0;
          src_d   = w_q;
          state_d = StGrant;
        end else begin
          k_d     = '0;
          moved_d = 1'b0;
          state_d = StDrain;
        end
      end

      // move inbox words into the deque
      StDrain: begin
        if (k_q < CW'(DRAIN_BATCH) && !ib_empty) begin
          ib_re   = 1'b1;
          head_we = 1'b1;
          icnt_we = 1'b1;
          icnt_wd = icnt_w - IBC_W'(1);
          state_d = StDrainWr;
        end else if (moved_q && !dq_empty) begin
          bot_we  = 1'b1;
          bot_wd  = bot_m1;
          dq_re   = 1'b1;
          dq_idx  = bot_m1;
          rd_ib_d = 1'b0;
          src_d   = w_q;
          state_d = StGrant;
        end else begin
          state_d = StStealInit;
        end
      end

      StDrainWr: begin
        if (!dq_full) begin
          dq_we    = 1'b1;
          dq_wdata = ib_rd_q;
          bot_we   = 1'b1;
          k_d      = k_q + CW'(1);
          moved_d  = 1'b1;
          state_d  = StDrain;
        end else if (out_free) begin
          emit     = 1'b1;
          e_kind   = KindInline;
          e_task   = ib_rd_q;
          e_last   = 1'b0;
          k_d      = k_q + CW'(1);
          moved_d  = 1'b1;
          state_d  = StDrain;
        end
      end

      StStealInit: begin
        x_d     = NW'(cur_q[wid_w]) + NW'(1);
        k_d     = CW'(1);
        state_d = StStealMod;
      end

      StStealMod: begin
        if (x_q >= n) begin
          x_d = x_q - n;
        end else begin
          w_d     = WW'(x_q);
          state_d = StSteal;
        end
      end

      // one victim per cycle, oldest deque word then oldest inbox word
      StSteal: begin
        if (k_q > CW'(n)) begin
          if (out_free) begin
            emit    = 1'b1;
            state_d = StIdle;
          end
        end else if (w_q != wid_w && !dq_empty) begin
          top_we  = 1'b1;
          dq_re   = 1'b1;
          dq_idx  = top_w;
          cur_we  = 1'b1;
          rd_ib_d = 1'b0;
          src_d   = w_q;
          state_d = StGrant;
        end else if (w_q != wid_w && !ib_empty) begin
          ib_re   = 1'b1;
          head_we = 1'b1;
          icnt_we = 1'b1;
          icnt_wd = icnt_w - IBC_W'(1);
          cur_we  = 1'b1;
          rd_ib_d = 1'b1;
          src_d   = w_q;
          state_d = StGrant;
        end else begin
          k_d = k_q + CW'(1);
          w_d = w_next;
        end
      end

      StGrant: begin
        if (out_free) begin
          emit    = 1'b1;
          e_kind  = KindGranted;
          e_task  = rd_ib_q ? ib_rd_q : dq_rd_q;
          e_tgt   = 3'(src_q);
          state_d = StIdle;
        end
      end

      default: state_d = StIdle;
    endcase
  end

  // output register
  always_comb begin
    out_valid_d = out_valid_q;
    if (emit) begin
      out_valid_d = 1'b1;
    end else if (out_ready_i) begin
      out_valid_d = 1'b0;
    end
  end

  // control registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= StIdle;
      cfg_q       <= 4'd8;
      rr_q        <= '0;
      pend_q      <= '0;
      out_valid_q <= 1'b0;
      w_q         <= '0;
      for (int i = 0; i < WORKERS; i++) begin
        top_q[i]  <= '0;
        bot_q[i]  <= '0;
        head_q[i] <= '0;
        icnt_q[i] <= '0;
        cur_q[i]  <= WW'(i);
      end
    end else begin
      state_q     <= state_d;
      rr_q        <= rr_d;
      pend_q      <= pend_d;
      out_valid_q <= out_valid_d;
      w_q         <= w_d;
      if (cfg_we_i) cfg_q <= cfg_data_i;
      if (top_we)   top_q[w_q]  <= top_wd;
      if (bot_we)   bot_q[w_q]  <= bot_wd;
      if (head_we)  head_q[w_q] <= head_wd;
      if (icnt_we)  icnt_q[w_q] <= icnt_wd;
      if (cur_we)   cur_q[wid_w] <= w_q;
    end
  end

  // working payload registers
  always_ff @(posedge clk_i) begin
    if (in_acc) begin
      wid_q  <= worker_id_i;
      tok_q  <= task_token_i;
    end
    x_q     <= x_d;
    k_q     <= k_d;
    moved_q <= moved_d;
    src_q   <= src_d;
    rd_ib_q <= rd_ib_d;
    if (emit) begin
      kind_q     <= e_kind;
      task_q     <= e_task;
      tgt_q      <= e_tgt;
      last_q     <= e_last;
      all_idle_q <= (pend_d == '0);
    end
  end

  // deque store
  always_ff @(posedge clk_i) begin
    if (dq_we) dq_mem[dq_addr] <= dq_wdata;
    if (dq_re) dq_rd_q <= dq_mem[dq_addr];
  end

  // inbox store
  always_ff @(posedge clk_i) begin
    if (ib_we) ib_mem[ib_addr] <= tok_q;
    if (ib_re) ib_rd_q <= ib_mem[ib_addr];
  end

  assign out_valid_o     = out_valid_q;
  assign kind_o          = kind_q;
  assign task_out_o      = task_q;
  assign target_worker_o = tgt_q;
  assign last_o          = last_q;
  assign all_idle_o      = all_idle_q;

  // one word in flight at a time
  a_one_word: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_acc |=> !in_ready_o) else $error("word accepted while busy");

  // occupancy bounds of the worker under work
  a_dq_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    dq_cnt <= DQI_W'(DEQUE_DEPTH)) else $error("deque over depth");

  a_ib_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    icnt_w <= IBC_W'(INBOX_DEPTH)) else $error("inbox over depth");

  // the mode decode only returns to idle after a final word
  a_last_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (emit && !e_last) |=> state_q != StIdle) else $error("overflow word ended input");

endmodule

`default_nettype wire
